// File: rtl/core/rcar_pkg.sv
// rcar_pkg: shared types and constants for the resolver cache with age replacement
// no dependencies; imported by the interfaces, the store and the top level
`default_nettype none

package rcar_pkg;

    localparam int KEY_W  = 64;
    localparam int ADDR_W = 32;
    localparam int SLOT_W = 4;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LK_SCAN,
        ST_AGE_SCAN,
        ST_VICTIM_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic entry_we;
        logic age_we;
    } mem_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/rcar_req_if.sv
// rcar_req_if: request channel of the resolver cache, valid/ready with payload
// depends on rcar_pkg for the field widths
`default_nettype none

interface rcar_req_if;
    import rcar_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [KEY_W-1:0]  domain_key;
    logic [ADDR_W-1:0] ip_addr;

    modport source (output valid, output req_type, output domain_key, output ip_addr,
                    input ready);
    modport sink   (input valid, input req_type, input domain_key, input ip_addr,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/rcar_rsp_if.sv
// rcar_rsp_if: response channel of the resolver cache, valid/ready with payload
// depends on rcar_pkg for the field widths
`default_nettype none

interface rcar_rsp_if;
    import rcar_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] ip_out;
    logic              evicted;

    modport source (output valid, output hit, output slot, output ip_out, output evicted,
                     input ready);
    modport sink   (input valid, input hit, input slot, input ip_out, input evicted,
                     output ready);
endinterface

`default_nettype wire

// File: rtl/core/resolver_cache_age_replace_unit.sv
// resolver_cache_age_replace_unit: fully associative key to address cache
// with oldest-age replacement; depends on rcar_pkg, rcar_req_if, rcar_rsp_if, rcar_mem
//
//   channel | dir | payload                           | handshake
//   req     | in  | req_type, domain_key, ip_addr     | valid/ready
//   rsp     | out | hit, slot, ip_out, evicted        | valid/ready
//
// one request at a time; the memories are scanned one entry per cycle
// lookup: scans the filled entries from slot 0 and ends early on a hit
// appending insert: written at accept; full: scan all ages, then write the victim
// ready returns in the cycle after the response is loaded
// reset empties the cache at once (fill count only), no clearing pass
// a finished response waits in the output register; a new request is taken meanwhile
`default_nettype none

module resolver_cache_age_replace_unit #(
    parameter int CACHE_DEPTH = 16,
    parameter int AGE_BITS    = 16
) (
    input  wire        clk,
    input  wire        rst_n,
    rcar_req_if.sink   req,
    rcar_rsp_if.source rsp
);
    import rcar_pkg::*;

    localparam int IDX_W   = $clog2(CACHE_DEPTH);
    localparam int CNT_W   = $clog2(CACHE_DEPTH + 1);
    localparam int ENTRY_W = KEY_W + ADDR_W;
    localparam logic [AGE_BITS-1:0] AGE_MAX   = {AGE_BITS{1'b1}};
    localparam logic [CNT_W-1:0]    DEPTH_CNT = CNT_W'(CACHE_DEPTH);
    localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(CACHE_DEPTH - 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [AGE_BITS-1:0] best_reg, best_next;
    logic [IDX_W-1:0]    victim_reg, victim_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [ADDR_W-1:0]   ip_reg, ip_next;
    logic                res_hit_reg, res_hit_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [ADDR_W-1:0]   res_ip_reg, res_ip_next;
    logic                res_evicted_reg, res_evicted_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_hit_reg, out_hit_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [ADDR_W-1:0]   out_ip_reg, out_ip_next;
    logic                out_evicted_reg, out_evicted_next;

    mem_ctrl_t           mem_ctrl;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  entry_wdata;
    logic [AGE_BITS-1:0] age_wdata;
    logic [ENTRY_W-1:0]  entry_rdata;
    logic [AGE_BITS-1:0] age_rdata;
    logic [AGE_BITS-1:0] age_inc;
    logic                key_match;

    rcar_mem #(
        .CACHE_DEPTH (CACHE_DEPTH),
        .AGE_BITS    (AGE_BITS)
    ) u_mem (
        .clk         (clk),
        .ctrl        (mem_ctrl),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .entry_wdata (entry_wdata),
        .age_wdata   (age_wdata),
        .entry_rdata (entry_rdata),
        .age_rdata   (age_rdata)
    );

    assign age_inc   = (age_rdata == AGE_MAX) ? AGE_MAX : age_rdata + AGE_BITS'(1);
    assign key_match = (entry_rdata[ADDR_W +: KEY_W] == key_reg);

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.hit     = out_hit_reg;
    assign rsp.slot    = out_slot_reg;
    assign rsp.ip_out  = out_ip_reg;
    assign rsp.evicted = out_evicted_reg;

    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        rd_cnt_next      = rd_cnt_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        best_next        = best_reg;
        victim_next      = victim_reg;
        key_next         = key_reg;
        ip_next          = ip_reg;
        res_hit_next     = res_hit_reg;
        res_slot_next    = res_slot_reg;
        res_ip_next      = res_ip_reg;
        res_evicted_next = res_evicted_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_hit_next     = out_hit_reg;
        out_slot_next    = out_slot_reg;
        out_ip_next      = out_ip_reg;
        out_evicted_next = out_evicted_reg;
        mem_ctrl         = '0;
        rd_addr          = rd_cnt_reg[IDX_W-1:0];
        wr_addr          = cmp_idx_reg;
        entry_wdata      = {key_reg, ip_reg};
        age_wdata        = age_inc;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    key_next         = req.domain_key;
                    ip_next          = req.ip_addr;
                    rd_cnt_next      = '0;
                    res_hit_next     = 1'b0;
                    res_slot_next    = '0;
                    res_ip_next      = '0;
                    res_evicted_next = 1'b0;
                    if (req.req_type == REQ_LOOKUP)
                    begin
                        state_next = ST_LK_SCAN;
                    end
                    else if (fill_reg < DEPTH_CNT)
                    begin
                        // append at the next free slot
                        mem_ctrl.entry_we = 1'b1;
                        mem_ctrl.age_we   = 1'b1;
                        wr_addr           = fill_reg[IDX_W-1:0];
                        entry_wdata       = {req.domain_key, req.ip_addr};
                        age_wdata         = '0;
                        fill_next         = fill_reg + CNT_W'(1);
                        res_slot_next     = SLOT_W'(fill_reg);
                        state_next        = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_AGE_SCAN;
                    end
                end
            end

            ST_LK_SCAN:
            begin
                if (rd_cnt_reg < fill_reg)
                begin
                    mem_ctrl.rd_en = 1'b1;
                    rd_cnt_next    = rd_cnt_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_cnt_reg[IDX_W-1:0];
                end
                if (cmp_valid_reg && key_match)
                begin
                    res_hit_next   = 1'b1;
                    res_slot_next  = SLOT_W'(cmp_idx_reg);
                    res_ip_next    = entry_rdata[ADDR_W-1:0];
                    cmp_valid_next = 1'b0;
                    state_next     = ST_FINISH;
                end
                else if (rd_cnt_reg >= fill_reg)
                begin
                    // miss: every filled entry compared
                    state_next = ST_FINISH;
                end
            end

            ST_AGE_SCAN:
            begin
                if (rd_cnt_reg < DEPTH_CNT)
                begin
                    mem_ctrl.rd_en = 1'b1;
                    rd_cnt_next    = rd_cnt_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_cnt_reg[IDX_W-1:0];
                end
                if (cmp_valid_reg)
                begin
                    // saturating age write-back, first oldest entry kept
                    mem_ctrl.age_we = 1'b1;
                    wr_addr         = cmp_idx_reg;
                    age_wdata       = age_inc;
                    if ((cmp_idx_reg == '0) || (age_rdata > best_reg))
                    begin
                        best_next   = age_rdata;
                        victim_next = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_VICTIM_WR;
                    end
                end
            end

            ST_VICTIM_WR:
            begin
                mem_ctrl.entry_we = 1'b1;
                mem_ctrl.age_we   = 1'b1;
                wr_addr           = victim_reg;
                entry_wdata       = {key_reg, ip_reg};
                age_wdata         = '0;
                res_hit_next      = 1'b0;
                res_slot_next     = SLOT_W'(victim_reg);
                res_ip_next       = '0;
                res_evicted_next  = 1'b1;
                state_next        = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_hit_next     = res_hit_reg;
                    out_slot_next    = res_slot_reg;
                    out_ip_next      = res_ip_reg;
                    out_evicted_next = res_evicted_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rd_cnt_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rd_cnt_reg    <= rd_cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg     <= cmp_idx_next;
        best_reg        <= best_next;
        victim_reg      <= victim_next;
        key_reg         <= key_next;
        ip_reg          <= ip_next;
        res_hit_reg     <= res_hit_next;
        res_slot_reg    <= res_slot_next;
        res_ip_reg      <= res_ip_next;
        res_evicted_reg <= res_evicted_next;
        out_hit_reg     <= out_hit_next;
        out_slot_reg    <= out_slot_next;
        out_ip_reg      <= out_ip_next;
        out_evicted_reg <= out_evicted_next;
    end

    // fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= DEPTH_CNT)
        else $error("fill count beyond cache depth");

    // eviction scan only runs on a full cache
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AGE_SCAN) |-> (fill_reg == DEPTH_CNT))
        else $error("age scan on a cache that is not full");

    // compare stage only live inside a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> ((state_reg == ST_LK_SCAN) || (state_reg == ST_AGE_SCAN)))
        else $error("compare stage valid outside a scan");

    // an eviction response never reports a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_evicted_reg) |-> !out_hit_reg)
        else $error("eviction response flagged as hit");

    // fill count moves only upward by one; only an appending insert changes it
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("fill count jumped");

endmodule

`default_nettype wire

// File: rtl/core/rcar_mem.sv
// rcar_mem: entry memory (key and address) and age memory, one shared read port
// and one shared write address, read data registered; depends on rcar_pkg
`default_nettype none

module rcar_mem #(
    parameter int CACHE_DEPTH = 16,
    parameter int AGE_BITS    = 16
) (
    input  wire                                              clk,
    input  wire  rcar_pkg::mem_ctrl_t                        ctrl,
    input  wire  [$clog2(CACHE_DEPTH)-1:0]                   rd_addr,
    input  wire  [$clog2(CACHE_DEPTH)-1:0]                   wr_addr,
    input  wire  [rcar_pkg::KEY_W+rcar_pkg::ADDR_W-1:0]      entry_wdata,
    input  wire  [AGE_BITS-1:0]                              age_wdata,
    output logic [rcar_pkg::KEY_W+rcar_pkg::ADDR_W-1:0]      entry_rdata,
    output logic [AGE_BITS-1:0]                              age_rdata
);
    import rcar_pkg::*;

    localparam int ENTRY_W = KEY_W + ADDR_W;

    logic [ENTRY_W-1:0]  entry_mem [CACHE_DEPTH];
    logic [AGE_BITS-1:0] age_mem   [CACHE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.entry_we)
        begin
            entry_mem[wr_addr] <= entry_wdata;
        end
        if (ctrl.rd_en)
        begin
            entry_rdata <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.age_we)
        begin
            age_mem[wr_addr] <= age_wdata;
        end
        if (ctrl.rd_en)
        begin
            age_rdata <= age_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
